>>> design/pcdfa_pkg.sv
// pcdfa_pkg: shared types and constants for the dock feature accumulator
// no dependencies; imported by the accumulator and its checker

package pcdfa_pkg;

    // request kinds
    localparam logic [1:0] KIND_POINT      = 2'd0;
    localparam logic [1:0] KIND_NEAR_CLEAR = 2'd1;
    localparam logic [1:0] KIND_SIDE_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_AIM_Y_OFFSET   = 2'd0;
    localparam logic [1:0] CFG_MIRROR_AXES    = 2'd1;
    localparam logic [1:0] CFG_CONTACT_OFFSET = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int COORD_W     = 16;
    localparam int SUM_W       = 36;
    localparam int COUNT_OUT_W = 20;

    // phase codes
    localparam logic PHASE_NEAREST = 1'b0;
    localparam logic PHASE_SIDE    = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COORD_W:0]   coord_ext_t;   // after offset and negation
    typedef logic signed [COORD_W+1:0] work_t;        // compare width
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [SUM_W:0]     sum_ext_t;

    localparam coord_t NEAR_X_NONE  = 16'sd9999;
    localparam coord_t MARKER_NONE  = -16'sd9999;

    localparam work_t NEAR_Z_MAX    = 18'sd230;
    localparam work_t FRONT_Y_LIM   = 18'sd310;
    localparam work_t SIDE_Z_MIN    = 18'sd100;
    localparam work_t SIDE_Z_MAX    = 18'sd420;
    localparam work_t SIDE_X_SPAN   = 18'sd353;   // 103 + 250 behind nearest hit
    localparam work_t BAND_INNER    = 18'sd160;
    localparam work_t BAND_OUTER    = 18'sd250;
    localparam work_t COORD_MAX     = 18'sd32767;
    localparam work_t COORD_MIN     = -18'sd32768;

    localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

endpackage

>>> design/point_cloud_dock_feature_accumulator.sv
// point_cloud_dock_feature_accumulator: dock finding point accumulator
// depends on pcdfa_pkg
//
// usage:
//   input channel (in_valid/in_ready) carries one request per cycle: a point
//   (kind, point_x/y/z, from_marker) or a phase command (nearest clear, side clear)
//   output channel (out_valid/out_ready) returns exactly one result per request:
//   the accumulator state after that request was applied
//   configuration port (cfg_we, cfg_index, cfg_data) writes aim_y_offset,
//   mirror_axes and contact_offset; write only while no request is in flight
// timing:
//   latency is 2 cycles: an input register, then the state registers, which
//   also serve as the result register
//   throughput is 1 request per cycle; the single classify-and-add step between
//   the input register and the state registers sets it
// stall behavior:
//   while out_ready is low the result holds, and the input register still takes
//   one more request; in_ready drops only when both stages are full
// reset:
//   rst_n clears the configuration to 0 / 0 / 130, the phase to nearest,
//   nearest_x to 9999, marker to -9999, and all band sums and counts to 0

module point_cloud_dock_feature_accumulator
    import pcdfa_pkg::*;
#(
    parameter int COUNT_BITS = 20
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    // request channel
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             kind,
    input  logic signed [15:0]     point_x,
    input  logic signed [15:0]     point_y,
    input  logic signed [15:0]     point_z,
    input  logic                   from_marker,

    // result channel
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   phase,
    output logic signed [15:0]     nearest_x,
    output logic signed [15:0]     nearest_y,
    output logic signed [15:0]     nearest_z,
    output logic signed [15:0]     marker_lateral,
    output logic signed [35:0]     left_sum,
    output logic [19:0]            left_count,
    output logic signed [35:0]     right_sum,
    output logic [19:0]            right_count
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // configuration registers
    logic signed [6:0] aim_y_offset_reg;
    logic              mirror_axes_reg;
    logic [9:0]        contact_offset_reg;

    // input register stage
    logic              in_valid_reg;
    logic [1:0]        kind_reg;
    coord_t            px_reg;
    coord_t            py_reg;
    coord_t            pz_reg;
    logic              marker_pt_reg;

    // accumulator state, also the result register
    logic              out_valid_reg;
    logic              phase_reg;
    coord_t            near_x_reg;
    coord_t            near_y_reg;
    coord_t            near_z_reg;
    coord_t            marker_reg;
    sum_t              left_sum_reg;
    logic [COUNT_BITS-1:0] left_count_reg;
    sum_t              right_sum_reg;
    logic [COUNT_BITS-1:0] right_count_reg;

    logic              phase_next;
    coord_t            near_x_next;
    coord_t            near_y_next;
    coord_t            near_z_next;
    coord_t            marker_next;
    sum_t              left_sum_next;
    logic [COUNT_BITS-1:0] left_count_next;
    sum_t              right_sum_next;
    logic [COUNT_BITS-1:0] right_count_next;

    // handshake: the state advances when the result slot is free or being taken
    logic advance;
    logic in_accept;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign in_accept = in_valid && in_ready;

    // point conditioning: aim offset, then optional mirror of x and y
    coord_ext_t y_off;
    coord_ext_t x_adj;
    coord_ext_t y_adj;
    work_t      xw;
    work_t      yw;
    work_t      zw;
    work_t      near_xw;
    work_t      markw;

    assign y_off   = coord_ext_t'(py_reg) + coord_ext_t'(aim_y_offset_reg);
    assign x_adj   = mirror_axes_reg ? -coord_ext_t'(px_reg) : coord_ext_t'(px_reg);
    assign y_adj   = mirror_axes_reg ? -y_off : y_off;
    assign xw      = work_t'(x_adj);
    assign yw      = work_t'(y_adj);
    assign zw      = work_t'(pz_reg);
    assign near_xw = work_t'(near_x_reg);
    assign markw   = work_t'(marker_reg);

    // classification
    logic   front_hit;
    logic   side_z_ok;
    logic   side_x_ok;
    logic   right_band;
    logic   left_band;
    coord_t marker_sat;

    assign front_hit = (zw <= NEAR_Z_MAX) && (yw < FRONT_Y_LIM) && (yw > -FRONT_Y_LIM)
                     && (xw > work_t'({1'b0, contact_offset_reg})) && (xw < near_xw);
    assign side_z_ok  = (zw >= SIDE_Z_MIN) && (zw <= SIDE_Z_MAX);
    assign side_x_ok  = (xw > near_xw) && (xw < near_xw + SIDE_X_SPAN);
    assign right_band = (yw < markw - BAND_INNER) && (yw > markw - BAND_OUTER);
    assign left_band  = (yw > markw + BAND_INNER) && (yw < markw + BAND_OUTER);

    always_comb
    begin
        if (yw > COORD_MAX)
        begin
            marker_sat = coord_t'(COORD_MAX);
        end
        else if (yw < COORD_MIN)
        begin
            marker_sat = coord_t'(COORD_MIN);
        end
        else
        begin
            marker_sat = coord_t'(yw);
        end
    end

    // band sums with saturation to the 36-bit range
    sum_ext_t left_add;
    sum_ext_t right_add;
    sum_t     left_sat;
    sum_t     right_sat;

    assign left_add  = sum_ext_t'(left_sum_reg) + sum_ext_t'(x_adj);
    assign right_add = sum_ext_t'(right_sum_reg) + sum_ext_t'(x_adj);

    always_comb
    begin
        if (left_add[SUM_W] != left_add[SUM_W-1])
        begin
            left_sat = left_add[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            left_sat = left_add[SUM_W-1:0];
        end
        if (right_add[SUM_W] != right_add[SUM_W-1])
        begin
            right_sat = right_add[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            right_sat = right_add[SUM_W-1:0];
        end
    end

    // state update for the request in the input register
    always_comb
    begin
        phase_next       = phase_reg;
        near_x_next      = near_x_reg;
        near_y_next      = near_y_reg;
        near_z_next      = near_z_reg;
        marker_next      = marker_reg;
        left_sum_next    = left_sum_reg;
        left_count_next  = left_count_reg;
        right_sum_next   = right_sum_reg;
        right_count_next = right_count_reg;

        case (kind_reg)
            KIND_POINT:
            begin
                if (phase_reg == PHASE_NEAREST)
                begin
                    if (marker_pt_reg)
                    begin
                        marker_next = marker_sat;
                    end
                    else if (front_hit)
                    begin
                        near_x_next = coord_t'(xw);
                        near_y_next = coord_t'(yw);
                        near_z_next = pz_reg;
                    end
                end
                else if (!marker_pt_reg && side_z_ok && side_x_ok)
                begin
                    // right band has priority; a full count freezes its sum
                    if (right_band)
                    begin
                        if (right_count_reg != COUNT_MAX)
                        begin
                            right_count_next = right_count_reg + 1'b1;
                            right_sum_next   = right_sat;
                        end
                    end
                    else if (left_band)
                    begin
                        if (left_count_reg != COUNT_MAX)
                        begin
                            left_count_next = left_count_reg + 1'b1;
                            left_sum_next   = left_sat;
                        end
                    end
                end
            end
            KIND_NEAR_CLEAR:
            begin
                phase_next  = PHASE_NEAREST;
                marker_next = MARKER_NONE;
                near_x_next = NEAR_X_NONE;
                near_y_next = '0;
                near_z_next = '0;
            end
            KIND_SIDE_CLEAR:
            begin
                phase_next       = PHASE_SIDE;
                left_sum_next    = '0;
                left_count_next  = '0;
                right_sum_next   = '0;
                right_count_next = '0;
            end
            default:
            begin
                // unused kind leaves the state as it is
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aim_y_offset_reg   <= '0;
            mirror_axes_reg    <= 1'b0;
            contact_offset_reg <= 10'd130;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_AIM_Y_OFFSET:   aim_y_offset_reg   <= cfg_data[6:0];
                CFG_MIRROR_AXES:    mirror_axes_reg    <= cfg_data[0];
                CFG_CONTACT_OFFSET: contact_offset_reg <= cfg_data;
                default:
                begin
                    // writes past the register list are dropped
                end
            endcase
        end
    end

    // input register: valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // input register: payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg      <= kind;
            px_reg        <= point_x;
            py_reg        <= point_y;
            pz_reg        <= point_z;
            marker_pt_reg <= from_marker;
        end
    end

    // accumulator state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            phase_reg       <= PHASE_NEAREST;
            near_x_reg      <= NEAR_X_NONE;
            near_y_reg      <= '0;
            near_z_reg      <= '0;
            marker_reg      <= MARKER_NONE;
            left_sum_reg    <= '0;
            left_count_reg  <= '0;
            right_sum_reg   <= '0;
            right_count_reg <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg   <= 1'b1;
                phase_reg       <= phase_next;
                near_x_reg      <= near_x_next;
                near_y_reg      <= near_y_next;
                near_z_reg      <= near_z_next;
                marker_reg      <= marker_next;
                left_sum_reg    <= left_sum_next;
                left_count_reg  <= left_count_next;
                right_sum_reg   <= right_sum_next;
                right_count_reg <= right_count_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result ports come straight off the state registers
    assign out_valid      = out_valid_reg;
    assign phase          = phase_reg;
    assign nearest_x      = near_x_reg;
    assign nearest_y      = near_y_reg;
    assign nearest_z      = near_z_reg;
    assign marker_lateral = marker_reg;
    assign left_sum       = left_sum_reg;
    assign left_count     = COUNT_OUT_W'(left_count_reg);
    assign right_sum      = right_sum_reg;
    assign right_count    = COUNT_OUT_W'(right_count_reg);

endmodule

>>> design/pcdfa_checker.sv
// pcdfa_checker: port-level assertions for the dock feature accumulator
// depends on pcdfa_pkg; bound to point_cloud_dock_feature_accumulator below

module pcdfa_checker
    import pcdfa_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               phase,
    input logic signed [15:0] nearest_x,
    input logic signed [15:0] nearest_y,
    input logic signed [35:0] left_sum,
    input logic signed [35:0] right_sum
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(phase) && $stable(nearest_x)
            && $stable(left_sum) && $stable(right_sum))
    else $error("stalled result changed");

    // back pressure only when both the input stage and the result are held
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
    else $error("input blocked while result path is free");

    // nearest x is the empty marker or a positive forward distance below it
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> nearest_x > 16'sd0 && nearest_x <= NEAR_X_NONE)
    else $error("nearest x out of range");

    // nearest y always lies inside the front window
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> nearest_y > -16'sd310 && nearest_y < 16'sd310)
    else $error("nearest y outside front window");

endmodule

bind point_cloud_dock_feature_accumulator pcdfa_checker u_pcdfa_checker (.*);
